FILE: hdl/rccrc_pkg.sv
// Shared types, constants and CRC helper for the region-checked CRC-32 engine.
`timescale 1ns / 1ps
`default_nettype none
package rccrc_pkg;

  localparam int ADDR_BITS = 24;

  localparam int ADDR_W  = 24;
  localparam int COUNT_W = 24;
  localparam int END_W   = 25;
  localparam int CRC_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [END_W-1:0] ADDR_MASK = END_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hffff_ffff;
  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hedb8_8320;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_DONE      = 2'd2,
    ST_IDLE_BYTE = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BEGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;

  typedef struct packed {
    logic [END_W-1:0]   region_begin;
    logic [END_W-1:0]   region_end;
  } window_t;

  // One reflected 4-bit step; the inner loop builds the nibble table entry.
  function automatic logic [CRC_W-1:0] crc_nibble_step(input logic [CRC_W-1:0] crc);
    logic [CRC_W-1:0] t;
    t = {28'd0, crc[3:0]};
    for (int i = 0; i < 4; i++) begin
      t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
    end
    return (crc >> 4) ^ t;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rccrc_crc_byte.sv
// Byte-wide reflected CRC-32 update as two nibble table steps.
`timescale 1ns / 1ps
`default_nettype none
module rccrc_crc_byte
  import rccrc_pkg::*;
(
  input  wire logic [CRC_W-1:0] crc_in,
  input  wire logic [7:0]       data_in,
  output logic      [CRC_W-1:0] crc_out
);

  logic [CRC_W-1:0] mixed;
  logic [CRC_W-1:0] half;

  always_comb begin
    mixed   = crc_in ^ {24'd0, data_in};
    half    = crc_nibble_step(mixed);
    crc_out = crc_nibble_step(half);
  end

endmodule
`default_nettype wire

FILE: hdl/rccrc_window_check.sv
// Checks a start request against the configured protected window.
`timescale 1ns / 1ps
`default_nettype none
module rccrc_window_check
  import rccrc_pkg::*;
(
  input  wire window_t            window,
  input  wire logic [ADDR_W-1:0]  start_addr,
  input  wire logic [COUNT_W-1:0] byte_count,
  output logic                    ok
);

  logic [END_W-1:0] addr;
  logic [END_W-1:0] begin_m;
  logic [END_W-1:0] room;

  always_comb begin
    addr    = {1'b0, start_addr} & ADDR_MASK;
    begin_m = window.region_begin & ADDR_MASK;
    room    = window.region_end - addr;
    ok = (byte_count != '0) && (addr >= begin_m) && (addr < window.region_end)
         && ({1'b0, byte_count} <= room);
  end

endmodule
`default_nettype wire

FILE: hdl/region_checked_crc32_engine.sv
// Top level of the region-checked CRC-32 engine.
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per cycle unless a result waits on out_ready. A start item
// is judged against the window [region_begin, region_end) and answered
// accepted or rejected; data bytes then update a reflected CRC-32 and the
// last counted byte returns the final checksum. Items pass the input
// register, then the result register, with the byte CRC update and window
// compare between those two registers. Bytes that produce no result never
// wait on the output side. Write the window registers only while idle.
module region_checked_crc32_engine
  import rccrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  operation,
  input  wire logic [ADDR_W-1:0]     start_addr,
  input  wire logic [COUNT_W-1:0]    byte_count,
  input  wire logic [7:0]            data_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic [CRC_W-1:0]           checksum
);

  window_t          window;
  logic [CRC_W-1:0] running_crc;
  logic [COUNT_W-1:0] bytes_left;
  logic             busy;

  logic               s1_valid;
  op_t                s1_op;
  logic [ADDR_W-1:0]  s1_addr;
  logic [COUNT_W-1:0] s1_count;
  logic [7:0]         s1_byte;

  logic             win_ok;
  logic [CRC_W-1:0] crc_upd;
  logic             has_result;
  logic             s1_fire;
  logic             data_live;
  logic             last_byte;

  logic [CRC_W-1:0]   running_crc_next;
  logic [COUNT_W-1:0] bytes_left_next;
  logic               busy_next;
  status_t            status_next;
  logic [CRC_W-1:0]   checksum_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_REGION_BEGIN) begin
        window.region_begin <= {1'b0, cfg_data[ADDR_W-1:0]};
      end else if (cfg_index == CFG_REGION_END) begin
        window.region_end <= cfg_data[END_W-1:0];
      end
    end
  end

  rccrc_window_check u_check (
    .window     (window),
    .start_addr (s1_addr),
    .byte_count (s1_count),
    .ok         (win_ok)
  );

  rccrc_crc_byte u_crc (
    .crc_in  (running_crc),
    .data_in (s1_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    data_live  = busy && (bytes_left != '0);
    last_byte  = (bytes_left == COUNT_W'(1));
    has_result = (s1_op == OP_START) || !data_live || last_byte;
    s1_fire    = s1_valid && (!has_result || !out_valid || out_ready);
    in_ready   = !s1_valid || s1_fire;

    running_crc_next = running_crc;
    bytes_left_next  = bytes_left;
    busy_next        = busy;
    status_next      = ST_IDLE_BYTE;
    checksum_next    = '0;

    if (s1_op == OP_START) begin
      running_crc_next = CRC_ALL_ONES;
      if (win_ok) begin
        bytes_left_next = s1_count;
        busy_next       = 1'b1;
        status_next     = ST_ACCEPTED;
      end else begin
        bytes_left_next = '0;
        busy_next       = 1'b0;
        status_next     = ST_REJECTED;
      end
    end else if (data_live) begin
      if (last_byte) begin
        running_crc_next = CRC_ALL_ONES;
        bytes_left_next  = '0;
        busy_next        = 1'b0;
        status_next      = ST_DONE;
        checksum_next    = crc_upd ^ CRC_ALL_ONES;
      end else begin
        running_crc_next = crc_upd;
        bytes_left_next  = bytes_left - COUNT_W'(1);
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= op_t'(operation);
      s1_addr  <= start_addr;
      s1_count <= byte_count;
      s1_byte  <= data_byte;
    end
  end

  // check state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_ALL_ONES;
      bytes_left  <= '0;
      busy        <= 1'b0;
    end else if (s1_fire) begin
      running_crc <= running_crc_next;
      bytes_left  <= bytes_left_next;
      busy        <= busy_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      status   <= status_next;
      checksum <= checksum_next;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for region_checked_crc32_engine: window checks and CRC-32 results.
`timescale 1ns / 1ps
module tb;
  import rccrc_pkg::*;

  localparam int IDLE_PCT = 23;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_GUARD = 20000;
  localparam int PHASE_ITEMS = 80;
  localparam int RANDOM_PHASES = 5;
  localparam int STEADY_PHASE = 2;
  localparam int FULL_END_PHASE = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [END_W-1:0] ADDR_SPAN = 25'h100_0000;
  localparam logic [END_W-1:0] END_MAX = 25'h1FF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_TOP = 24'hFF_FFFF;

  typedef struct {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [7:0]         data;
  } region_item_t;

  typedef struct {
    status_t          status;
    logic [CRC_W-1:0] checksum;
  } crc_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  operation = 1'b0;
  logic [ADDR_W-1:0]     start_addr = '0;
  logic [COUNT_W-1:0]    byte_count = '0;
  logic [7:0]            data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [CRC_W-1:0]      checksum;

  region_item_t pending_items[$];
  crc_result_t  expected_results[$];
  int           mismatches = 0;
  bit           steady = 1'b0;

  // predicted engine state and window
  logic [ADDR_W-1:0]  win_begin = '0;
  logic [END_W-1:0]   win_end = '0;
  logic [CRC_W-1:0]   crc_acc = CRC_ALL_ONES;
  logic [COUNT_W-1:0] bytes_left = '0;
  bit                 run_active = 1'b0;

  region_checked_crc32_engine u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .start_addr(start_addr), .byte_count(byte_count), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .checksum(checksum)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void predict_region_crc(input op_t op, input logic [ADDR_W-1:0] addr,
                                             input logic [COUNT_W-1:0] count,
                                             input logic [7:0] data);
    crc_result_t r;
    logic [END_W:0] room;
    logic fits;
    int k;
    r.status = ST_ACCEPTED;
    r.checksum = '0;
    if (op == OP_START) begin
      room = {1'b0, win_end} - {2'b0, addr};
      fits = (count != 0) && (addr >= win_begin) && ({1'b0, addr} < win_end)
             && ({2'b0, count} <= room);
      crc_acc = CRC_ALL_ONES;
      run_active = fits;
      bytes_left = fits ? count : '0;
      r.status = fits ? ST_ACCEPTED : ST_REJECTED;
      expected_results.push_back(r);
    end else if (!run_active || bytes_left == 0) begin
      r.status = ST_IDLE_BYTE;
      expected_results.push_back(r);
    end else begin
      crc_acc = crc_acc ^ {24'd0, data};
      for (k = 0; k < 8; k++) begin
        crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
      end
      bytes_left = bytes_left - COUNT_W'(1);
      if (bytes_left == 0) begin
        r.status = ST_DONE;
        r.checksum = crc_acc ^ CRC_ALL_ONES;
        expected_results.push_back(r);
        crc_acc = CRC_ALL_ONES;
        run_active = 1'b0;
      end
    end
  endfunction

  function automatic void queue_start(input logic [ADDR_W-1:0] addr,
                                      input logic [COUNT_W-1:0] count);
    region_item_t it;
    it.op = OP_START;
    it.addr = addr;
    it.count = count;
    it.data = 8'($urandom);
    pending_items.push_back(it);
  endfunction

  function automatic void queue_byte(input logic [7:0] data);
    region_item_t it;
    it.op = OP_DATA;
    it.addr = ADDR_W'($urandom);
    it.count = COUNT_W'($urandom);
    it.data = data;
    pending_items.push_back(it);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_REGION_BEGIN) win_begin = value[ADDR_W-1:0];
    else if (idx == CFG_REGION_END) win_end = value[END_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    int guard;
    guard = 0;
    while ((pending_items.size() != 0 || in_valid || expected_results.size() != 0)
           && guard < QUIET_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= QUIET_GUARD) report_mismatch("results still outstanding");
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver: predicts each transfer as it is accepted
  always @(posedge clk) begin : item_driver
    region_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_region_crc(op_t'(operation), start_addr, byte_count,
                                                   data_byte);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          operation <= nxt.op;
          start_addr <= nxt.addr;
          byte_count <= nxt.count;
          data_byte <= nxt.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    crc_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending, status %0d", status));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          if (checksum !== want.checksum)
            report_mismatch($sformatf("checksum %08h, want %08h", checksum, want.checksum));
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    int n, r, len, room, k, phase;
    logic [END_W-1:0] b25, e25, hi_addr, a25;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window at reset values is empty
    queue_start(24'h0, 24'd1);
    queue_byte(8'hA5);
    wait_quiet();

    write_reg(CFG_REGION_BEGIN, '0);
    write_reg(CFG_REGION_END, ADDR_SPAN);
    queue_start(24'h0, 24'd0);
    queue_start(ADDR_TOP, 24'd1);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_start(24'h0, 24'hFF_FFFF);
    queue_byte(8'h12);
    queue_start(24'h00_0100, 24'd3);
    queue_byte(8'h31);
    queue_byte(8'h32);
    queue_byte(8'h33);
    queue_start(24'hFF_FFF0, 24'h10);
    queue_start(24'hFF_FFF0, 24'h11);
    queue_byte(8'h5A);
    wait_quiet();

    // upper bit of the begin write is dropped
    write_reg(CFG_REGION_BEGIN, END_MAX);
    write_reg(CFG_REGION_END, END_MAX);
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    queue_start(24'hFF_FFFE, 24'd1);
    queue_start(ADDR_TOP, 24'hFF_FFFF);
    queue_byte(8'hC3);
    queue_start(ADDR_TOP, 24'd2);
    queue_byte(8'h80);
    queue_byte(8'h01);
    wait_quiet();

    // inverted, then empty window
    write_reg(CFG_REGION_BEGIN, 25'h500);
    write_reg(CFG_REGION_END, 25'h400);
    queue_start(24'h450, 24'd1);
    queue_start(24'h500, 24'd1);
    wait_quiet();
    write_reg(CFG_REGION_BEGIN, 25'h800);
    write_reg(CFG_REGION_END, 25'h800);
    queue_start(24'h800, 24'd1);
    wait_quiet();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase == STEADY_PHASE);
      b25 = END_W'($urandom_range(0, ADDR_TOP));
      e25 = b25 + END_W'($urandom_range(1, 4096));
      if (phase == FULL_END_PHASE) e25 = END_MAX;
      write_reg(CFG_REGION_BEGIN, {1'($urandom_range(0, 1)), b25[ADDR_W-1:0]});
      write_reg(CFG_REGION_END, e25);
      hi_addr = (e25 > {1'b0, ADDR_TOP}) ? {1'b0, ADDR_TOP} : e25 - END_W'(1);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          a25 = END_W'($urandom_range(b25, hi_addr));
          room = int'(e25 - a25);
          len = $urandom_range(1, (r % 10 == 0) ? 40 : 12);
          if (len > room) len = room;
          queue_start(a25[ADDR_W-1:0], COUNT_W'(len));
          if ($urandom_range(0, 19) == 0) len = $urandom_range(0, len - 1);
          for (k = 0; k < len; k++) queue_byte(8'($urandom));
          n += len + 1;
        end else if (r < 80) begin
          case ($urandom_range(0, 3))
            0: a25 = b25 - END_W'(1);
            1: a25 = b25;
            2: a25 = hi_addr;
            default: a25 = e25;
          endcase
          room = int'(e25 - a25);
          queue_start(a25[ADDR_W-1:0], ($urandom_range(0, 2) == 0) ? '0 :
                      COUNT_W'(room + $urandom_range(0, 1)));
          n++;
        end else if (r < 90) begin
          queue_start(ADDR_W'($urandom), COUNT_W'($urandom));
          n++;
        end else begin
          queue_byte(8'($urandom));
          n++;
        end
      end
      // zero length start always rejects, so the engine ends the phase idle
      queue_start(ADDR_W'($urandom), '0);
      wait_quiet();
    end
    steady = 1'b0;

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/rccrc_pkg.sv
hdl/rccrc_crc_byte.sv
hdl/rccrc_window_check.sv
hdl/region_checked_crc32_engine.sv
tb/tb.sv
